@@ rtl/core/hpb_pkg.sv @@
package hpb_pkg;

  // Field and counter widths fixed by the stream format.
  localparam int PIX_W     = 32;
  localparam int PIX_BYTES = 4;
  localparam int CTR_W     = 12;
  localparam int DIM_W     = 13;
  localparam int TAPCFG_W  = 4;
  localparam int OFS_W     = 3;
  localparam int WGT_W     = 16;
  localparam int WORD_W    = 64;
  localparam int CFGIDX_W  = 3;
  localparam int NUM_WGT   = 8;

  // Linear position row * width + column, plus the centre shift.
  localparam int LIN_W = DIM_W + CTR_W;

  // Accumulator: byte times Q1.15 weight summed over up to eight taps.
  localparam int ACC_W  = 8 + WGT_W + 3;
  localparam int FRAC_W = 15;

  // Default tap count limit and image dimension limit.
  localparam int MAX_TAPS_DEF = 8;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(4096);

  // Register reset values.
  localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(480);
  localparam logic [TAPCFG_W-1:0] TAPS_RST   = TAPCFG_W'(1);
  localparam logic [OFS_W-1:0]    CENTRE_RST = '0;
  localparam logic [WORD_W-1:0]   WLOW_RST   = WORD_W'(32768);
  localparam logic [WORD_W-1:0]   WHIGH_RST  = '0;

  localparam logic [7:0] BYTE_MAX = 8'hff;

  // Configuration register indexes.
  typedef enum logic [CFGIDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_TAPS   = 3'd2,
    CFG_CENTRE = 3'd3,
    CFG_WLOW   = 3'd4,
    CFG_WHIGH  = 3'd5
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POS,
    ST_DIV,
    ST_CHK,
    ST_MAC,
    ST_PACK
  } state_t;

  // Clamp an image dimension to the range 1 to 4096.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/hpb_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hpb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hpb_pkg::LIN_W-1:0]   dividend,
  input  logic [hpb_pkg::DIM_W-1:0]   divisor,
  output logic                        done,
  output logic [hpb_pkg::LIN_W-1:0]   quotient,
  output logic [hpb_pkg::DIM_W-1:0]   remainder
);

  localparam int LW  = hpb_pkg::LIN_W;
  localparam int DW  = hpb_pkg::DIM_W;
  localparam int CNT_W = $clog2(LW + 1);

  logic [LW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      trial;
  logic             ge;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, quo_r[LW-1]};
    ge       = trial >= {1'b0, divisor};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quo_nxt = {quo_r[LW-2:0], ge};
      if (cnt_r == CNT_W'(LW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/core/horizontal_pixel_blur_top.sv @@
// Horizontal blur pass: takes 32-bit pixels in row-major order (in_tuser marks the first
// pixel of an image) and, for every pixel at least centre_offset in from each image edge,
// returns one blurred pixel with its column and row. Each byte is the sum over the taps of
// byte times an unsigned Q1.15 weight, truncated by 15 bits and saturated to 255; border
// pixels give no result. One pixel is handled at a time and in_tready is low while it is
// worked on. A pixel that gives no result ends after the position step, or after the divide
// and the border check when it lies inside the window but off the valid area; a pixel that
// gives a result goes on to one shared four-lane multiply-accumulate pass per tap and the
// pack step. The 25-step serial divider turns the centre's linear position into column and
// row. Configuration writes are always taken and must only be made while the block is idle.
module horizontal_pixel_blur_top #(
  parameter int MAX_TAPS = hpb_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // pixel_word [31:0]
  input  logic                          in_tuser,   // frame_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // blurred_pixel [31:0], pixel_column
                                                    // [43:32], pixel_row [55:44]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpb_pkg::CFGIDX_W-1:0]  cfg_index,
  input  logic [hpb_pkg::WORD_W-1:0]    cfg_data
);

  localparam int CW     = hpb_pkg::CTR_W;
  localparam int DW     = hpb_pkg::DIM_W;
  localparam int LW     = hpb_pkg::LIN_W;
  localparam int KW     = hpb_pkg::TAPCFG_W;
  localparam int AW     = hpb_pkg::ACC_W;
  localparam int NB     = hpb_pkg::PIX_BYTES;
  localparam int TIDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // Configuration registers.
  logic [DW-1:0]                 width_r, height_r;
  logic [KW-1:0]                 taps_r;
  logic [hpb_pkg::OFS_W-1:0]     centre_r;
  logic [hpb_pkg::WORD_W-1:0]    wlow_r, whigh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= hpb_pkg::WIDTH_RST;
      height_r <= hpb_pkg::HEIGHT_RST;
      taps_r   <= hpb_pkg::TAPS_RST;
      centre_r <= hpb_pkg::CENTRE_RST;
      wlow_r   <= hpb_pkg::WLOW_RST;
      whigh_r  <= hpb_pkg::WHIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hpb_pkg::CFG_WIDTH:  width_r  <= cfg_data[DW-1:0];
        hpb_pkg::CFG_HEIGHT: height_r <= cfg_data[DW-1:0];
        hpb_pkg::CFG_TAPS:   taps_r   <= cfg_data[KW-1:0];
        hpb_pkg::CFG_CENTRE: centre_r <= cfg_data[hpb_pkg::OFS_W-1:0];
        hpb_pkg::CFG_WLOW:   wlow_r   <= cfg_data;
        hpb_pkg::CFG_WHIGH:  whigh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective settings after range clamping.
  logic [DW-1:0] w_eff, h_eff;
  logic [KW-1:0] k_eff, k_m1;

  always_comb begin
    w_eff = hpb_pkg::clamp_dim(width_r);
    h_eff = hpb_pkg::clamp_dim(height_r);
    k_eff = taps_r;
    if (taps_r == '0) begin
      k_eff = KW'(1);
    end else if (taps_r > KW'(MAX_TAPS)) begin
      k_eff = KW'(MAX_TAPS);
    end
    k_m1 = k_eff - KW'(1);
  end

  // Sequencer state and control.
  hpb_pkg::state_t state_r, state_nxt;
  logic in_req, div_start, div_done, mac_clear, mac_en, out_load;
  logic p_ok, border_ok, last_tap;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [TIDX_W-1:0] tap_r, tap_nxt;

  assign in_req = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpb_pkg::ST_IDLE: if (in_req) state_nxt = hpb_pkg::ST_MUL;
      hpb_pkg::ST_MUL:  state_nxt = hpb_pkg::ST_POS;
      hpb_pkg::ST_POS:  state_nxt = p_ok ? hpb_pkg::ST_DIV : hpb_pkg::ST_IDLE;
      hpb_pkg::ST_DIV:  if (div_done) state_nxt = hpb_pkg::ST_CHK;
      hpb_pkg::ST_CHK:  state_nxt = border_ok ? hpb_pkg::ST_MAC : hpb_pkg::ST_IDLE;
      hpb_pkg::ST_MAC:  if (last_tap) state_nxt = hpb_pkg::ST_PACK;
      hpb_pkg::ST_PACK: if (!out_tvalid_r || out_tready) state_nxt = hpb_pkg::ST_IDLE;
      default:          state_nxt = hpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mac_clear = 1'b0;
    mac_en    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      hpb_pkg::ST_IDLE: in_tready = 1'b1;
      hpb_pkg::ST_POS:  div_start = p_ok;
      hpb_pkg::ST_CHK:  mac_clear = 1'b1;
      hpb_pkg::ST_MAC:  mac_en    = 1'b1;
      hpb_pkg::ST_PACK: out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // Pixel window, newest in entry 0, and position counters.
  logic [31:0]   win_r [MAX_TAPS];
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CW-1:0] col0, row0;
  logic [CW-1:0] pos_col_r, pos_row_r;
  logic [CW:0]   col_inc, row_inc;

  always_comb begin
    col0    = in_tuser ? '0 : col_r;
    row0    = in_tuser ? '0 : row_r;
    col_inc = {1'b0, col0} + (CW+1)'(1);
    row_inc = {1'b0, row0} + (CW+1)'(1);
    col_nxt = col_inc[CW-1:0];
    row_nxt = row0;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_req) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The window is part of the block's reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_req) begin
      win_r[0] <= in_tdata;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      pos_col_r <= col0;
      pos_row_r <= row0;
    end
  end

  // Linear position of the pixel and of its centre.
  logic [LW-1:0] prod_full, prod_r, lin, centre;

  assign prod_full = pos_row_r * w_eff;

  always_ff @(posedge clk) begin
    if (state_r == hpb_pkg::ST_MUL) begin
      prod_r <= prod_full;
    end
  end

  always_comb begin
    lin    = prod_r + LW'(pos_col_r);
    p_ok   = lin >= LW'(k_m1);
    centre = lin - LW'(k_m1) + LW'(centre_r);
  end

  // Centre column and row from the serial divider.
  logic [LW-1:0] cy;
  logic [DW-1:0] cx;

  hpb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (centre),
    .divisor   (w_eff),
    .done      (div_done),
    .quotient  (cy),
    .remainder (cx)
  );

  always_comb begin
    border_ok = (cx >= DW'(centre_r))
             && ((DW+1)'(cx) + (DW+1)'(centre_r) < (DW+1)'(w_eff))
             && (cy >= LW'(centre_r))
             && ((LW+1)'(cy) + (LW+1)'(centre_r) < (LW+1)'(h_eff));
  end

  logic [CW-1:0] res_col_r, res_row_r;

  always_ff @(posedge clk) begin
    if (state_r == hpb_pkg::ST_CHK) begin
      res_col_r <= cx[CW-1:0];
      res_row_r <= cy[CW-1:0];
    end
  end

  // Shared four-lane multiply-accumulate, one tap per cycle.
  logic [2*hpb_pkg::WORD_W-1:0] wgt_all;
  logic [hpb_pkg::WGT_W-1:0]    wgt;
  logic [KW-1:0]                win_idx;
  logic [31:0]                  win_sel;
  logic [AW-1:0]                acc_r [NB];
  logic [AW-1:0]                acc_nxt [NB];

  always_comb begin
    wgt_all  = {whigh_r, wlow_r};
    wgt      = wgt_all[hpb_pkg::WGT_W*tap_r +: hpb_pkg::WGT_W];
    win_idx  = k_m1 - KW'(tap_r);
    win_sel  = win_r[win_idx[TIDX_W-1:0]];
    last_tap = KW'(tap_r) == k_m1;
    tap_nxt  = tap_r + TIDX_W'(1);
    for (int j = 0; j < NB; j++) begin
      acc_nxt[j] = acc_r[j] + AW'(win_sel[8*j +: 8]) * AW'(wgt);
    end
  end

  always_ff @(posedge clk) begin
    if (mac_clear) begin
      tap_r <= '0;
      for (int j = 0; j < NB; j++) begin
        acc_r[j] <= '0;
      end
    end else if (mac_en) begin
      tap_r <= tap_nxt;
      for (int j = 0; j < NB; j++) begin
        acc_r[j] <= acc_nxt[j];
      end
    end
  end

  // Truncate, saturate and pack each byte.
  logic [31:0] blur_px;

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      if (|acc_r[j][AW-1:hpb_pkg::FRAC_W+8]) begin
        blur_px[8*j +: 8] = hpb_pkg::BYTE_MAX;
      end else begin
        blur_px[8*j +: 8] = acc_r[j][hpb_pkg::FRAC_W +: 8];
      end
    end
  end

  // Output register.
  logic [55:0] out_data_r;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hpb_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {res_row_r, res_col_r, blur_px};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // The block is not ready in the cycle after it takes a request.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> !in_tready)
    else $error("in_tready high right after a request");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == hpb_pkg::ST_DIV)
    else $error("divider done outside the divide state");

  // The tap index never runs past the taps in use.
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hpb_pkg::ST_MAC |-> KW'(tap_r) <= k_m1)
    else $error("tap index beyond tap count");

  // A new result only appears after the pack step.
  a_out_from_pack: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == hpb_pkg::ST_PACK))
    else $error("result raised outside the pack step");

endmodule
